// ===== hdl/jdwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Joystick wheel mixer package
// Widths, fixed-point scaling, the sine polynomial coefficients and the
// per-gear speed and turn-ratio tables shared by the mixer modules.
// ----------------------------------------------------------------------------
package jdwm_pkg;

  localparam int ANGLE_BITS = 16;

  localparam int DIR_W  = 16;
  localparam int DEFL_W = 16;
  localparam int GEAR_W = 3;
  localparam int SPD_W  = 13;

  localparam logic [ANGLE_BITS-1:0] ANG_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] ANG_QTR  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  localparam int ZONE_W = ANGLE_BITS + 7;
  localparam logic [ZONE_W-1:0] ZONE_MUL = ZONE_W'(72);
  localparam logic [ZONE_W-1:0] ZONE_LO  = ZONE_W'(17) << ANGLE_BITS;
  localparam logic [ZONE_W-1:0] ZONE_HI  = ZONE_W'(19) << ANGLE_BITS;

  localparam int M_W       = ANGLE_BITS - 1;
  localparam int U_W       = 31;
  localparam int U_SH      = 32 - ANGLE_BITS;
  localparam int FRAC_SH   = 30;
  localparam int SIN_FRAC  = 24;
  localparam int S_W       = SIN_FRAC + 1;
  localparam int SIN_DROP  = FRAC_SH - SIN_FRAC;
  localparam int SIN_TAPS  = 7;
  localparam logic [U_W+1:0] SIN_RND = (U_W+2)'(1) << (SIN_DROP - 1);
  localparam logic [U_W+1-SIN_DROP:0] S_ONE = (U_W+2-SIN_DROP)'(1) << SIN_FRAC;

  localparam logic [U_W-1:0] SIN_COEF [SIN_TAPS] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
    31'd172272, 31'd3864, 31'd61
  };

  localparam int GEAR_TOP = 5;
  localparam logic [DEFL_W-1:0] DEFL_ONE = DEFL_W'(32768);

  localparam logic [11:0] TOP_SPEED [6] = '{
    12'd500, 12'd400, 12'd900, 12'd1600, 12'd2000, 12'd2500
  };
  localparam logic [6:0] FWD_RATIO [6] = '{7'd40, 7'd50, 7'd35, 7'd30, 7'd25, 7'd25};
  localparam logic [6:0] REV_RATIO [6] = '{7'd50, 7'd50, 7'd40, 7'd30, 7'd30, 7'd30};
  localparam logic [7:0] PCT = 8'd100;

  localparam int P_W     = 27;
  localparam int LIN_W   = ANGLE_BITS + 5;
  localparam int PL_W    = P_W + LIN_W;
  localparam int A_W     = 31;
  localparam int SP_W    = P_W + A_W;
  localparam int SINE_SH = 15 + SIN_FRAC;
  localparam int LIN_SH  = 13 + ANGLE_BITS;

  localparam int X_W      = 18;
  localparam int Q_W      = 12;
  localparam int RECIP_SH = 24;
  localparam logic [X_W-1:0] HALF_UNIT = X_W'(50);
  localparam logic [X_W-1:0] UNIT_DIV  = X_W'(100);
  localparam logic [X_W-1:0] RECIP_100 = X_W'(167772);

endpackage

// ===== hdl/jdwm_sine.sv =====
// ----------------------------------------------------------------------------
// Quarter-wave sine pipeline
// Evaluates the odd Q30 polynomial by Horner steps, one multiply per stage,
// and rounds the result to Q24 with saturation at one.
// ----------------------------------------------------------------------------
module jdwm_sine (
  input  logic                        clk,
  input  logic [jdwm_pkg::M_W-1:0]    m,
  output logic [jdwm_pkg::S_W-1:0]    s
);
  import jdwm_pkg::*;

  logic [U_W-1:0]     u_in;
  logic [2*U_W-1:0]   sq;
  logic [U_W-1:0]     u_q   [0:SIN_TAPS-1];
  logic [U_W-1:0]     u2_q  [0:SIN_TAPS-2];
  logic [U_W-1:0]     t_q   [1:SIN_TAPS-1];
  logic [U_W-1:0]     t_in  [1:SIN_TAPS-1];
  logic [2*U_W-1:0]   hprod [1:SIN_TAPS-1];
  logic [U_W-1:0]     t_next[1:SIN_TAPS-1];
  logic [2*U_W-1:0]   fprod;
  logic [U_W+1:0]     srnd;
  logic [U_W+1-SIN_DROP:0] sh;

  assign u_in = {m, {U_SH{1'b0}}};
  assign sq   = (2*U_W)'(u_in) * (2*U_W)'(u_in);

  always_comb begin
    for (int i = 1; i < SIN_TAPS; i++) begin
      t_in[i]   = (i == 1) ? SIN_COEF[SIN_TAPS-1] : t_q[(i > 1) ? i - 1 : 1];
      hprod[i]  = (2*U_W)'(t_in[i]) * (2*U_W)'(u2_q[i-1]);
      t_next[i] = U_W'({1'b0, SIN_COEF[SIN_TAPS-1-i]} - hprod[i][2*U_W-1:FRAC_SH]);
    end
  end

  assign fprod = (2*U_W)'(t_q[SIN_TAPS-1]) * (2*U_W)'(u_q[SIN_TAPS-1]);
  assign srnd  = {1'b0, fprod[2*U_W-1:FRAC_SH]} + SIN_RND;
  assign sh    = srnd[U_W+1:SIN_DROP];

  always_ff @(posedge clk) begin
    u_q[0]  <= u_in;
    u2_q[0] <= sq[FRAC_SH+U_W-1:FRAC_SH];
    for (int i = 1; i < SIN_TAPS; i++) begin
      u_q[i] <= u_q[i-1];
      t_q[i] <= t_next[i];
    end
    for (int i = 1; i < SIN_TAPS - 1; i++) begin
      u2_q[i] <= u2_q[i-1];
    end
    s <= (sh > S_ONE) ? S_W'(S_ONE) : sh[S_W-1:0];
  end

endmodule

// ===== hdl/joystick_differential_wheel_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// Joystick to differential wheel speed mixer
// The result word of each accepted start is strobed by done.
// Throughput: one word per cycle; busy stays low, the 14-stage pipeline is fully
// pipelined and set by the chain of multipliers in the sine and scaling path.
// Reset clears the valid bits and done; data registers are not reset.
// ----------------------------------------------------------------------------
module joystick_differential_wheel_mixer_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [jdwm_pkg::DIR_W-1:0]             direction,
  input  logic [jdwm_pkg::DEFL_W-1:0]            deflection,
  input  logic [jdwm_pkg::GEAR_W-1:0]            gear,
  output logic                                   done,
  output logic signed [jdwm_pkg::SPD_W-1:0]      left_speed,
  output logic signed [jdwm_pkg::SPD_W-1:0]      right_speed,
  output logic                                   straight_zone
);
  import jdwm_pkg::*;

  typedef struct packed {
    logic [DEFL_W-1:0]     defl;
    logic [GEAR_W-1:0]     g;
    logic [M_W-1:0]        m;
    logic [ANGLE_BITS-1:0] y;
    logic [7:0]            c;
    logic [7:0]            c2;
    logic [6:0]            k;
    logic [6:0]            w;
    logic                  neg_pre;
    logic                  sine_neg;
    logic                  swap;
    logic                  zone;
  } stg1_t;

  typedef struct packed {
    logic [P_W-1:0]   p;
    logic [LIN_W-1:0] lin_mag;
    logic [6:0]       k;
    logic [6:0]       w;
    logic             sine_neg;
    logic             lin_neg;
    logic             swap;
    logic             zone;
  } stg2_t;

  typedef struct packed {
    logic [P_W-1:0]  p;
    logic [PL_W-1:0] plin;
    logic [6:0]      k;
    logic [6:0]      w;
    logic            sine_neg;
    logic            lin_neg;
    logic            swap;
    logic            zone;
  } mix_t;

  function automatic logic [SPD_W-1:0] finish(input logic [Q_W-1:0] q0,
                                              input logic [X_W-1:0] x,
                                              input logic           neg);
    logic [X_W-1:0]   rem;
    logic [Q_W-1:0]   q;
    logic [SPD_W-1:0] v;
    rem = x - X_W'(X_W'(q0) * UNIT_DIV);
    q   = (rem >= UNIT_DIV) ? q0 + Q_W'(1) : q0;
    v   = {1'b0, q};
    return neg ? -v : v;
  endfunction

  logic                  vld [1:14];

  logic [ANGLE_BITS-1:0] d;
  logic [ANGLE_BITS-1:0] x;
  logic                  fwd;
  logic                  hi;
  logic [GEAR_W-1:0]     gs;
  logic [6:0]            w_i;
  logic [6:0]            r_i;
  logic [ZONE_W-1:0]     dz;
  stg1_t                 r1_next;
  stg1_t                 r1_q;

  logic [ANGLE_BITS+7:0] cy;
  logic [ANGLE_BITS+5:0] c2q;
  logic signed [ANGLE_BITS+8:0] diff;
  logic [ANGLE_BITS+8:0] dabs;
  logic [DEFL_W+11:0]    pfull;
  stg2_t                 r2_next;
  stg2_t                 r2_q;

  mix_t                  mix3_next;
  mix_t                  mix_q [3:13];

  logic [S_W-1:0]        sine_s;
  logic [31:0]           ks;
  logic [A_W-1:0]        a_q;
  logic [SP_W-1:0]       spos_q;
  logic [X_W-1:0]        xs_q;
  logic [X_W-1:0]        xl_q;
  logic [X_W-1:0]        xs_d;
  logic [X_W-1:0]        xl_d;
  logic [2*X_W-1:0]      ps;
  logic [2*X_W-1:0]      pl;
  logic [Q_W-1:0]        q0s_q;
  logic [Q_W-1:0]        q0l_q;
  logic [SPD_W-1:0]      sv;
  logic [SPD_W-1:0]      lv;

  assign busy = 1'b0;

  always_comb begin
    d   = ANGLE_BITS'(direction);
    fwd = (d <= ANG_HALF);
    x   = fwd ? d : d - ANG_HALF;
    hi  = (x >= ANG_QTR);
    gs  = (gear > GEAR_W'(GEAR_TOP)) ? GEAR_W'(GEAR_TOP) : gear;
    w_i = FWD_RATIO[gs];
    r_i = REV_RATIO[gs];
    dz  = ZONE_W'(d) * ZONE_MUL;

    r1_next.defl     = (deflection > DEFL_ONE) ? DEFL_ONE : deflection;
    r1_next.g        = gs;
    r1_next.m        = hi ? M_W'(ANG_HALF - x) : M_W'(x);
    r1_next.y        = (fwd && hi) ? ANG_HALF - x : x;
    r1_next.c        = fwd ? PCT + {1'b0, w_i} : {1'b0, r_i} + {1'b0, w_i};
    r1_next.c2       = (!fwd && hi) ? {r_i, 1'b0} + {1'b0, w_i} : {1'b0, w_i};
    r1_next.k        = fwd ? 7'(PCT - {1'b0, w_i}) : r_i - w_i;
    r1_next.w        = w_i;
    r1_next.neg_pre  = !fwd && !hi;
    r1_next.sine_neg = fwd ? hi : !hi;
    r1_next.swap     = !hi;
    r1_next.zone     = fwd && (dz >= ZONE_LO) && (dz <= ZONE_HI);
  end

  always_comb begin
    cy    = (ANGLE_BITS+8)'(r1_q.c) * (ANGLE_BITS+8)'(r1_q.y);
    c2q   = {r1_q.c2, {(ANGLE_BITS-2){1'b0}}};
    diff  = $signed({1'b0, cy}) - $signed({3'b000, c2q});
    dabs  = diff[ANGLE_BITS+8] ? (ANGLE_BITS+9)'(-diff) : (ANGLE_BITS+9)'(diff);
    pfull = (DEFL_W+12)'(r1_q.defl) * (DEFL_W+12)'(TOP_SPEED[r1_q.g]);

    r2_next.p        = pfull[P_W-1:0];
    r2_next.lin_mag  = dabs[LIN_W-1:0];
    r2_next.k        = r1_q.k;
    r2_next.w        = r1_q.w;
    r2_next.sine_neg = r1_q.sine_neg;
    r2_next.lin_neg  = r1_q.neg_pre ^ diff[ANGLE_BITS+8] ^ r1_q.swap;
    r2_next.swap     = r1_q.swap;
    r2_next.zone     = r1_q.zone;
  end

  always_comb begin
    mix3_next.p        = r2_q.p;
    mix3_next.plin     = PL_W'(r2_q.p) * PL_W'(r2_q.lin_mag);
    mix3_next.k        = r2_q.k;
    mix3_next.w        = r2_q.w;
    mix3_next.sine_neg = r2_q.sine_neg;
    mix3_next.lin_neg  = r2_q.lin_neg;
    mix3_next.swap     = r2_q.swap;
    mix3_next.zone     = r2_q.zone;
  end

  jdwm_sine u_sine (
    .clk (clk),
    .m   (r1_q.m),
    .s   (sine_s)
  );

  assign ks = 32'(mix_q[9].k) * 32'(sine_s);
  assign ps = (2*X_W)'(xs_q) * (2*X_W)'(RECIP_100);
  assign pl = (2*X_W)'(xl_q) * (2*X_W)'(RECIP_100);
  assign sv = finish(q0s_q, xs_d, mix_q[13].sine_neg);
  assign lv = finish(q0l_q, xl_d, mix_q[13].lin_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 14; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[1] <= start && !busy;
      for (int i = 2; i <= 14; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign done = vld[14];

  always_ff @(posedge clk) begin
    r1_q     <= r1_next;
    r2_q     <= r2_next;
    mix_q[3] <= mix3_next;
    for (int i = 4; i <= 13; i++) begin
      mix_q[i] <= mix_q[i-1];
    end
    a_q    <= A_W'(ks) + (A_W'(mix_q[9].w) << SIN_FRAC);
    spos_q <= SP_W'(mix_q[10].p) * SP_W'(a_q);
    xs_q   <= spos_q[SINE_SH+X_W-1:SINE_SH] + HALF_UNIT;
    xl_q   <= mix_q[11].plin[LIN_SH+X_W-1:LIN_SH] + HALF_UNIT;
    q0s_q  <= ps[RECIP_SH+Q_W-1:RECIP_SH];
    q0l_q  <= pl[RECIP_SH+Q_W-1:RECIP_SH];
    xs_d   <= xs_q;
    xl_d   <= xl_q;
    left_speed    <= mix_q[13].swap ? sv : lv;
    right_speed   <= mix_q[13].swap ? lv : sv;
    straight_zone <= mix_q[13].zone;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##14 done)
    else $error("accepted word did not produce a result after the pipeline latency");

  a_zero_defl: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && deflection == '0) |-> ##14 (left_speed == '0 && right_speed == '0))
    else $error("zero deflection gave a nonzero wheel speed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (left_speed >= -13'sd2500 && left_speed <= 13'sd2500 &&
              right_speed >= -13'sd2500 && right_speed <= 13'sd2500))
    else $error("wheel speed outside the gear limits");

  a_zone_sign: assert property (@(posedge clk) disable iff (rst)
    (done && straight_zone) |-> (!left_speed[SPD_W-1] &&
                                 (right_speed == '0 || right_speed[SPD_W-1])))
    else $error("straight zone result does not drive both wheels forward");

endmodule
